### design/trcq_pkg.sv
// Shared types and constants for the tile rectangle collision query block.
`timescale 1ns / 1ps
`default_nettype none
package trcq_pkg;

   localparam int DEF_MAX_COLUMNS = 64;
   localparam int DEF_MAX_ROWS    = 64;

   localparam int TILE_W  = 8;   // tile coordinate, holds up to 255
   localparam int COORD_W = 16;  // pixel coordinate

   // configuration register indexes
   localparam logic [1:0] CSR_TILE_SHIFT  = 2'd0;
   localparam logic [1:0] CSR_MAP_COLUMNS = 2'd1;
   localparam logic [1:0] CSR_MAP_ROWS    = 2'd2;
   localparam logic [1:0] CSR_MAP_PRESENT = 2'd3;

   localparam logic [2:0] RST_TILE_SHIFT  = 3'd3;
   localparam logic [6:0] RST_MAP_COLUMNS = 7'd64;
   localparam logic [6:0] RST_MAP_ROWS    = 7'd64;
   localparam logic       RST_MAP_PRESENT = 1'b0;

   localparam logic ACTION_WRITE = 1'b0;

   // flag map codes
   localparam logic [7:0] CODE_FULL   = 8'd0;
   localparam logic [7:0] CODE_TOP    = 8'd5;
   localparam logic [7:0] CODE_BOTTOM = 8'd6;
   localparam logic [7:0] CODE_LEFT   = 8'd7;
   localparam logic [7:0] CODE_RIGHT  = 8'd8;
   localparam logic [7:0] CODE_EMPTY  = 8'd255;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_SCAN,
      KIND_FREE
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic                       wr_ok;
      logic [5:0]                 col;
      logic [5:0]                 row;
      logic [7:0]                 code;
      logic [TILE_W-1:0]          tx1;
      logic [TILE_W-1:0]          ty1;
      logic [TILE_W-1:0]          tx2;
      logic [TILE_W-1:0]          ty2;
      logic signed [COORD_W-1:0]  x1;
      logic signed [COORD_W-1:0]  y1;
      logic signed [COORD_W-1:0]  x2;
      logic signed [COORD_W-1:0]  y2;
   } entry_type;

endpackage
`default_nettype wire

### design/trcq_front.sv
// Front end: classifies each beat and turns a query into clamped tile bounds.
`timescale 1ns / 1ps
`default_nettype none
module trcq_front #(
   parameter int MAX_COLUMNS = trcq_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = trcq_pkg::DEF_MAX_ROWS
) (
   input  wire logic                                 req_action,
   input  wire logic [5:0]                           req_entry_col,
   input  wire logic [5:0]                           req_entry_row,
   input  wire logic [7:0]                           req_entry_code,
   input  wire logic signed [trcq_pkg::COORD_W-1:0]  req_rect_left,
   input  wire logic signed [trcq_pkg::COORD_W-1:0]  req_rect_top,
   input  wire logic signed [trcq_pkg::COORD_W-1:0]  req_rect_right,
   input  wire logic signed [trcq_pkg::COORD_W-1:0]  req_rect_bottom,
   input  wire logic [2:0]                           tile_size_shift,
   input  wire logic [6:0]                           map_columns,
   input  wire logic [6:0]                           map_rows,
   input  wire logic                                 map_present,
   output      trcq_pkg::entry_type                  entry
);

   logic [7:0]         cols;
   logic [7:0]         rows;
   logic signed [15:0] fx1, fy1, fx2, fy2;
   logic signed [16:0] cols_m1, rows_m1;
   logic signed [16:0] lo_x, lo_y, hi_x, hi_y;
   logic               empty;

   assign cols = ({1'b0, map_columns} > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS)
                                                         : {1'b0, map_columns};
   assign rows = ({1'b0, map_rows} > 8'(MAX_ROWS)) ? 8'(MAX_ROWS)
                                                   : {1'b0, map_rows};
   assign cols_m1 = $signed({9'b0, cols}) - 17'sd1;
   assign rows_m1 = $signed({9'b0, rows}) - 17'sd1;

   // floor division by the tile size
   assign fx1 = req_rect_left   >>> tile_size_shift;
   assign fy1 = req_rect_top    >>> tile_size_shift;
   assign fx2 = req_rect_right  >>> tile_size_shift;
   assign fy2 = req_rect_bottom >>> tile_size_shift;

   always_comb begin
      lo_x = (fx1 < 16'sd0) ? 17'sd0 : $signed({fx1[15], fx1});
      lo_y = (fy1 < 16'sd0) ? 17'sd0 : $signed({fy1[15], fy1});
      hi_x = ($signed({fx2[15], fx2}) > cols_m1) ? cols_m1 : $signed({fx2[15], fx2});
      hi_y = ($signed({fy2[15], fy2}) > rows_m1) ? rows_m1 : $signed({fy2[15], fy2});
      empty = (lo_x > hi_x) || (lo_y > hi_y);
   end

   always_comb begin
      entry.col   = req_entry_col;
      entry.row   = req_entry_row;
      entry.code  = req_entry_code;
      entry.wr_ok = ({2'b0, req_entry_col} < 8'(MAX_COLUMNS)) &&
                    ({2'b0, req_entry_row} < 8'(MAX_ROWS));
      entry.tx1   = lo_x[trcq_pkg::TILE_W-1:0];
      entry.ty1   = lo_y[trcq_pkg::TILE_W-1:0];
      entry.tx2   = hi_x[trcq_pkg::TILE_W-1:0];
      entry.ty2   = hi_y[trcq_pkg::TILE_W-1:0];
      entry.x1    = req_rect_left;
      entry.y1    = req_rect_top;
      entry.x2    = req_rect_right;
      entry.y2    = req_rect_bottom;
      if (req_action == trcq_pkg::ACTION_WRITE) begin
         entry.kind = trcq_pkg::KIND_WRITE;
      end else if (!map_present || empty) begin
         entry.kind = trcq_pkg::KIND_FREE;
      end else begin
         entry.kind = trcq_pkg::KIND_SCAN;
      end
   end

endmodule
`default_nettype wire

### design/trcq_queue.sv
// Two-entry queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module trcq_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire trcq_pkg::entry_type push_entry,
   output      logic                full,
   output      logic                head_valid,
   output      trcq_pkg::entry_type head_entry,
   input  wire logic                pop
);

   trcq_pkg::entry_type ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = ent_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

### design/trcq_back.sv
// Back end: flag map memory, map writes and the pipelined tile scan.
`timescale 1ns / 1ps
`default_nettype none
module trcq_back #(
   parameter int MAX_COLUMNS = trcq_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = trcq_pkg::DEF_MAX_ROWS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [2:0]          tile_size_shift,
   input  wire logic                head_valid,
   input  wire trcq_pkg::entry_type head_entry,
   output      logic                pop,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic                rsp_is_free
);

   localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TW     = trcq_pkg::TILE_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   function automatic logic overlap(
      input logic signed [17:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2
   );
      return !((ax2 < bx1) || (bx2 < ax1) || (ay2 < by1) || (by2 < ay1));
   endfunction

   logic [7:0] map_mem [DEPTH];

   state_type           state_ff, state_in;
   trcq_pkg::entry_type cur_ff, cur_in;
   logic [TW-1:0]       tx_ff, tx_in, ty_ff, ty_in;
   logic [TW-1:0]       chk_tx_ff, chk_tx_in, chk_ty_ff, chk_ty_in;
   logic                chk_valid_ff, chk_valid_in;
   logic                chk_last_ff, chk_last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free_ff, rsp_free_in;
   logic [7:0]          rd_code_ff;

   logic                mem_we;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic                out_free, last_issue, hit, done;
   logic signed [17:0]  ts, hs, l, t, x1, y1, x2, y2;

   assign wr_addr = ADDR_W'(32'(head_entry.row) * 32'(MAX_COLUMNS) + 32'(head_entry.col));
   assign rd_addr = ADDR_W'(32'(ty_ff) * 32'(MAX_COLUMNS) + 32'(tx_ff));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[wr_addr] <= head_entry.code;
      end
      rd_code_ff <= map_mem[rd_addr];
   end

   // blocking test of the tile read in the previous cycle
   assign ts = 18'sd1 << tile_size_shift;
   assign hs = ts >>> 1;
   assign l  = 18'(chk_tx_ff) << tile_size_shift;
   assign t  = 18'(chk_ty_ff) << tile_size_shift;
   assign x1 = {{2{cur_ff.x1[15]}}, cur_ff.x1};
   assign y1 = {{2{cur_ff.y1[15]}}, cur_ff.y1};
   assign x2 = {{2{cur_ff.x2[15]}}, cur_ff.x2};
   assign y2 = {{2{cur_ff.y2[15]}}, cur_ff.y2};

   always_comb begin
      case (rd_code_ff)
         trcq_pkg::CODE_FULL:   hit = 1'b1;
         trcq_pkg::CODE_TOP:    hit = overlap(x1, y1, x2, y2, l, t, l + ts, t + hs);
         trcq_pkg::CODE_BOTTOM: hit = overlap(x1, y1, x2, y2, l, t + hs, l + ts, t + ts);
         trcq_pkg::CODE_LEFT:   hit = overlap(x1, y1, x2, y2, l, t, l + hs, t + ts);
         trcq_pkg::CODE_RIGHT:  hit = overlap(x1, y1, x2, y2, l + hs, t, l + ts, t + ts);
         default:               hit = 1'b0;
      endcase
   end

   assign done       = chk_valid_ff && (hit || chk_last_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_issue = (tx_ff == cur_ff.tx2) && (ty_ff == cur_ff.ty2);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      chk_valid_in = 1'b0;
      chk_tx_in    = tx_ff;
      chk_ty_in    = ty_ff;
      chk_last_in  = last_issue;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_free_in  = rsp_free_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               case (head_entry.kind)
                  trcq_pkg::KIND_WRITE: begin
                     pop    = 1'b1;
                     mem_we = head_entry.wr_ok;
                  end
                  trcq_pkg::KIND_FREE: begin
                     if (out_free) begin
                        pop          = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_free_in  = 1'b1;
                     end
                  end
                  trcq_pkg::KIND_SCAN: begin
                     if (out_free) begin
                        pop      = 1'b1;
                        cur_in   = head_entry;
                        tx_in    = head_entry.tx1;
                        ty_in    = head_entry.ty1;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (done) begin
               state_in = ST_IDLE;
            end else begin
               chk_valid_in = 1'b1;
               if (last_issue) begin
                  state_in = ST_DRAIN;
               end else if (ty_ff == cur_ff.ty2) begin
                  ty_in = cur_ff.ty1;
                  tx_in = tx_ff + TW'(1);
               end else begin
                  ty_in = ty_ff + TW'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_free_in  = !hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      chk_tx_ff   <= chk_tx_in;
      chk_ty_ff   <= chk_ty_in;
      chk_last_ff <= chk_last_in;
      rsp_free_ff <= rsp_free_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_is_free = rsp_free_ff;

endmodule
`default_nettype wire

### design/tile_rect_collision_query.sv
// A scanning query reads the map tile by tile up to the first blocking tile or the last
// tile of its bounds, then answers; a query that visits no tile is answered without a scan.
// The back end takes a new entry only after a scanning query has answered, and makes one
// map read per cycle while scanning; a write or a query that visits no tile needs no scan;
// the front takes a beat while the two-entry queue has room.
// Reset clears control state and config registers; the flag map is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module tile_rect_collision_query #(
   parameter int MAX_COLUMNS = trcq_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = trcq_pkg::DEF_MAX_ROWS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic                                req_action,
   input  wire logic [5:0]                          req_entry_col,
   input  wire logic [5:0]                          req_entry_row,
   input  wire logic [7:0]                          req_entry_code,
   input  wire logic signed [trcq_pkg::COORD_W-1:0] req_rect_left,
   input  wire logic signed [trcq_pkg::COORD_W-1:0] req_rect_top,
   input  wire logic signed [trcq_pkg::COORD_W-1:0] req_rect_right,
   input  wire logic signed [trcq_pkg::COORD_W-1:0] req_rect_bottom,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_is_free,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [3:0]                          paddr,
   input  wire logic [31:0]                         pwdata,
   output      logic [31:0]                         prdata,
   output      logic                                pready
);

   logic [2:0] shift_ff;
   logic [6:0] cols_ff;
   logic [6:0] rows_ff;
   logic       present_ff;
   logic       csr_wr;

   trcq_pkg::entry_type front_entry, head_entry;
   logic                q_full, head_valid, q_pop;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff   <= trcq_pkg::RST_TILE_SHIFT;
         cols_ff    <= trcq_pkg::RST_MAP_COLUMNS;
         rows_ff    <= trcq_pkg::RST_MAP_ROWS;
         present_ff <= trcq_pkg::RST_MAP_PRESENT;
      end else if (csr_wr) begin
         case (paddr[3:2])
            trcq_pkg::CSR_TILE_SHIFT:  shift_ff   <= pwdata[2:0];
            trcq_pkg::CSR_MAP_COLUMNS: cols_ff    <= pwdata[6:0];
            trcq_pkg::CSR_MAP_ROWS:    rows_ff    <= pwdata[6:0];
            trcq_pkg::CSR_MAP_PRESENT: present_ff <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         trcq_pkg::CSR_TILE_SHIFT:  prdata = {29'b0, shift_ff};
         trcq_pkg::CSR_MAP_COLUMNS: prdata = {25'b0, cols_ff};
         trcq_pkg::CSR_MAP_ROWS:    prdata = {25'b0, rows_ff};
         trcq_pkg::CSR_MAP_PRESENT: prdata = {31'b0, present_ff};
         default:                   prdata = 32'b0;
      endcase
   end

   assign req_stall = q_full;

   trcq_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .req_action      (req_action),
      .req_entry_col   (req_entry_col),
      .req_entry_row   (req_entry_row),
      .req_entry_code  (req_entry_code),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_right  (req_rect_right),
      .req_rect_bottom (req_rect_bottom),
      .tile_size_shift (shift_ff),
      .map_columns     (cols_ff),
      .map_rows        (rows_ff),
      .map_present     (present_ff),
      .entry           (front_entry)
   );

   trcq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_entry (front_entry),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (q_pop)
   );

   trcq_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .tile_size_shift (shift_ff),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_free     (rsp_is_free)
   );

endmodule
`default_nettype wire

### test/tile_rect_collision_query_tb.sv
// Self-checking testbench for the tile rectangle collision query block.
`timescale 1ns / 1ps
module tile_rect_collision_query_tb;

   localparam int MAX_COLUMNS = trcq_pkg::DEF_MAX_COLUMNS;
   localparam int MAX_ROWS    = trcq_pkg::DEF_MAX_ROWS;
   localparam int COORD_W     = trcq_pkg::COORD_W;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 16;

   localparam logic ACTION_QUERY = 1'b1;

   localparam logic [7:0] CODE_SOLID       = trcq_pkg::CODE_FULL;
   localparam logic [7:0] CODE_TOP_HALF    = trcq_pkg::CODE_TOP;
   localparam logic [7:0] CODE_BOTTOM_HALF = trcq_pkg::CODE_BOTTOM;
   localparam logic [7:0] CODE_LEFT_HALF   = trcq_pkg::CODE_LEFT;
   localparam logic [7:0] CODE_RIGHT_HALF  = trcq_pkg::CODE_RIGHT;
   localparam logic [7:0] CODE_OTHER       = 8'd77;
   localparam logic [7:0] CODE_EMPTY       = trcq_pkg::CODE_EMPTY;

   typedef struct {
      logic                      action;
      logic [5:0]                col;
      logic [5:0]                row;
      logic [7:0]                code;
      logic signed [COORD_W-1:0] rect_l;
      logic signed [COORD_W-1:0] rect_t;
      logic signed [COORD_W-1:0] rect_r;
      logic signed [COORD_W-1:0] rect_b;
   } request_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_action = 1'b0;
   logic [5:0]                req_entry_col = '0;
   logic [5:0]                req_entry_row = '0;
   logic [7:0]                req_entry_code = '0;
   logic signed [COORD_W-1:0] req_rect_left = '0;
   logic signed [COORD_W-1:0] req_rect_top = '0;
   logic signed [COORD_W-1:0] req_rect_right = '0;
   logic signed [COORD_W-1:0] req_rect_bottom = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_is_free;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [3:0]                paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   // shadow of the block's configuration and flag map
   logic [2:0]  cfg_shift   = trcq_pkg::RST_TILE_SHIFT;
   logic [6:0]  cfg_columns = trcq_pkg::RST_MAP_COLUMNS;
   logic [6:0]  cfg_rows    = trcq_pkg::RST_MAP_ROWS;
   logic        cfg_present = trcq_pkg::RST_MAP_PRESENT;
   logic [7:0]  tile_codes [0:MAX_COLUMNS*MAX_ROWS-1];

   request_type pending_requests [$];
   logic        expected_free [$];
   request_type next_req;
   logic        want_free;
   int          failures = 0;
   int          cycle_count = 0;
   bit          steady_phase = 1'b0;
   bit          hold_armed = 1'b0;
   bit          hold_taken = 1'b0;
   int          hold_left = 0;

   tile_rect_collision_query dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_entry_col   (req_entry_col),
      .req_entry_row   (req_entry_row),
      .req_entry_code  (req_entry_code),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_right  (req_rect_right),
      .req_rect_bottom (req_rect_bottom),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_free     (rsp_is_free),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic box_hit(input int x1, y1, x2, y2, bx1, by1, bx2, by2);
      return !(x2 < bx1 || bx2 < x1 || y2 < by1 || by2 < y1);
   endfunction

   function automatic logic predict_free(input logic signed [COORD_W-1:0] x1, y1, x2, y2);
      int   ts;
      int   hs;
      int   ncol;
      int   nrow;
      int   tx1;
      int   ty1;
      int   tx2;
      int   ty2;
      int   l;
      int   t;
      logic [7:0] code;
      logic hit;
      if (!cfg_present) return 1'b1;
      ts = 1 << cfg_shift;
      hs = ts / 2;
      ncol = (cfg_columns > MAX_COLUMNS) ? MAX_COLUMNS : int'(cfg_columns);
      nrow = (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
      tx1 = int'(x1) >>> cfg_shift;
      ty1 = int'(y1) >>> cfg_shift;
      tx2 = int'(x2) >>> cfg_shift;
      ty2 = int'(y2) >>> cfg_shift;
      if (tx1 < 0) tx1 = 0;
      if (ty1 < 0) ty1 = 0;
      if (tx2 > ncol - 1) tx2 = ncol - 1;
      if (ty2 > nrow - 1) ty2 = nrow - 1;
      for (int tx = tx1; tx <= tx2; tx++) begin
         for (int ty = ty1; ty <= ty2; ty++) begin
            code = tile_codes[ty * MAX_COLUMNS + tx];
            l = tx * ts;
            t = ty * ts;
            case (code)
               CODE_SOLID:       hit = 1'b1;
               CODE_TOP_HALF:    hit = box_hit(x1, y1, x2, y2, l, t, l + ts, t + hs);
               CODE_BOTTOM_HALF: hit = box_hit(x1, y1, x2, y2, l, t + hs, l + ts, t + ts);
               CODE_LEFT_HALF:   hit = box_hit(x1, y1, x2, y2, l, t, l + hs, t + ts);
               CODE_RIGHT_HALF:  hit = box_hit(x1, y1, x2, y2, l + hs, t, l + ts, t + ts);
               default:          hit = 1'b0;
            endcase
            if (hit) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [7:0] random_code();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8)  return CODE_SOLID;
      if (pick < 16) return CODE_TOP_HALF;
      if (pick < 24) return CODE_BOTTOM_HALF;
      if (pick < 32) return CODE_LEFT_HALF;
      if (pick < 40) return CODE_RIGHT_HALF;
      if (pick < 50) return 8'($urandom_range(255));
      return CODE_EMPTY;
   endfunction

   // row 2, columns 10..16 hold one tile of each kind, ringed by empty tiles
   function automatic logic [7:0] fill_code(input int col, input int row);
      if (row == 2) begin
         case (col)
            10: return CODE_SOLID;
            11: return CODE_TOP_HALF;
            12: return CODE_BOTTOM_HALF;
            13: return CODE_LEFT_HALF;
            14: return CODE_RIGHT_HALF;
            15: return CODE_EMPTY;
            16: return CODE_OTHER;
            default: ;
         endcase
      end
      if (row >= 1 && row <= 3 && col >= 9 && col <= 17) return CODE_EMPTY;
      return random_code();
   endfunction

   task automatic queue_write(input int col, input int row, input logic [7:0] code);
      request_type r;
      r.action = trcq_pkg::ACTION_WRITE;
      r.col = 6'(col);
      r.row = 6'(row);
      r.code = code;
      r.rect_l = COORD_W'($urandom);
      r.rect_t = COORD_W'($urandom);
      r.rect_r = COORD_W'($urandom);
      r.rect_b = COORD_W'($urandom);
      pending_requests.push_back(r);
   endtask

   task automatic queue_query(input int l, input int t, input int rr, input int b);
      request_type r;
      r.action = ACTION_QUERY;
      r.col = 6'($urandom);
      r.row = 6'($urandom);
      r.code = 8'($urandom);
      r.rect_l = COORD_W'(l);
      r.rect_t = COORD_W'(t);
      r.rect_r = COORD_W'(rr);
      r.rect_b = COORD_W'(b);
      pending_requests.push_back(r);
   endtask

   task automatic add_random_items(input int count);
      int ts;
      int span_x;
      int span_y;
      int l;
      int t;
      int w;
      int h;
      int pick;
      ts = 1 << cfg_shift;
      span_x = ((cfg_columns > MAX_COLUMNS) ? MAX_COLUMNS : int'(cfg_columns)) * ts;
      span_y = ((cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows)) * ts;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         l = $urandom_range(span_x + 4 * ts);
         l = l - 2 * ts;
         t = $urandom_range(span_y + 4 * ts);
         t = t - 2 * ts;
         w = $urandom_range(2 * ts);
         h = $urandom_range(2 * ts);
         if (pick < 20) begin
            queue_write($urandom_range(63), $urandom_range(63), random_code());
         end else if (pick < 23) begin
            queue_query($urandom, $urandom, $urandom, $urandom);
         end else if (pick < 30) begin
            if ($urandom_range(1)) queue_query(l, t, l - 1 - w, t + h);
            else queue_query(l, t, l + w, t - 1 - h);
         end else begin
            queue_query(l, t, l + w, t + h);
         end
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         trcq_pkg::CSR_TILE_SHIFT:  cfg_shift = value[2:0];
         trcq_pkg::CSR_MAP_COLUMNS: cfg_columns = value[6:0];
         trcq_pkg::CSR_MAP_ROWS:    cfg_rows = value[6:0];
         trcq_pkg::CSR_MAP_PRESENT: cfg_present = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int shift, input int cols, input int rows,
                             input int present);
      write_csr(trcq_pkg::CSR_TILE_SHIFT, shift);
      write_csr(trcq_pkg::CSR_MAP_COLUMNS, cols);
      write_csr(trcq_pkg::CSR_MAP_ROWS, rows);
      write_csr(trcq_pkg::CSR_MAP_PRESENT, present);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_free.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int shift, input int cols, input int rows,
                            input int present, input int count, input bit calm,
                            input bit hold);
      set_config(shift, cols, rows, present);
      steady_phase = calm;
      if (hold) hold_armed = 1'b1;
      add_random_items(count);
      wait_for_drain();
   endtask

   // request driver; the shadow state is updated on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_action == trcq_pkg::ACTION_WRITE)
               tile_codes[int'(req_entry_row) * MAX_COLUMNS + int'(req_entry_col)] =
                  req_entry_code;
            else
               expected_free.push_back(predict_free(req_rect_left, req_rect_top,
                                                    req_rect_right, req_rect_bottom));
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && (steady_phase || $urandom_range(99) >= 11)) begin
               next_req = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_action <= next_req.action;
               req_entry_col <= next_req.col;
               req_entry_row <= next_req.row;
               req_entry_code <= next_req.code;
               req_rect_left <= next_req.rect_l;
               req_rect_top <= next_req.rect_t;
               req_rect_right <= next_req.rect_r;
               req_rect_bottom <= next_req.rect_b;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall: random gaps plus one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_armed && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         hold_left <= 0;
         rsp_stall <= !steady_phase && ($urandom_range(99) < 11);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_free.size() == 0) begin
            failures++;
            $display("%0t: unexpected result beat, is_free expected none actual %0b",
                     $time, rsp_is_free);
         end else begin
            want_free = expected_free.pop_front();
            if (rsp_is_free !== want_free) begin
               failures++;
               $display("%0t: is_free mismatch, expected %0b actual %0b",
                        $time, want_free, rsp_is_free);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // map absent after reset: everything is free
      queue_query(-32768, -32768, 32767, 32767);
      queue_query(0, 0, 7, 7);
      // rows 0..3 and column 0 are loaded; every map in use stays inside them
      for (int row = 0; row < 4; row++)
         for (int col = 0; col < MAX_COLUMNS; col++)
            queue_write(col, row, fill_code(col, row));
      for (int row = 4; row < MAX_ROWS; row++)
         queue_write(0, row, random_code());
      wait_for_drain();

      set_config(3, 64, 4, 1);
      queue_query(82, 18, 83, 19);
      queue_query(90, 17, 91, 18);
      queue_query(90, 22, 91, 23);
      queue_query(98, 17, 99, 18);
      queue_query(98, 22, 99, 23);
      queue_query(105, 18, 106, 19);
      queue_query(110, 18, 111, 19);
      queue_query(108, 18, 109, 19);
      queue_query(113, 18, 114, 19);
      queue_query(117, 18, 118, 19);
      queue_query(121, 17, 126, 22);
      queue_query(129, 17, 134, 22);
      queue_query(96, 17, 96, 18);
      queue_query(90, 22, 89, 23);
      queue_query(82, 19, 83, 18);
      queue_query(-32768, -32768, 32767, 32767);
      queue_query(-32768, -32768, -1, -1);
      queue_query(32767, 32767, 32767, 32767);
      queue_write(15, 2, CODE_SOLID);
      queue_query(121, 17, 126, 22);
      wait_for_drain();

      run_phase(3, 64, 4, 1, 30, 1'b1, 1'b0);
      run_phase(0, 127, 4, 1, 30, 1'b0, 1'b1);
      run_phase(7, 1, 1, 1, 20, 1'b0, 1'b0);
      run_phase(2, 0, 40, 1, 15, 1'b0, 1'b0);
      run_phase(5, 1, 127, 1, 25, 1'b0, 1'b0);
      run_phase(4, 64, 64, 0, 15, 1'b0, 1'b0);
      run_phase(1, 33, 3, 1, 25, 1'b0, 1'b0);

      if (failures == 0 && expected_free.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
